@@ hdl/rakm_pkg.sv @@
// ----------------------------------------------------------------------------
// rakm_pkg
// Shared types, sizes and codes of the rotated-alphabet KMP matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package rakm_pkg;

    // Sizes
    localparam int P_DEPTH  = 1024;
    localparam int P_AW     = $clog2(P_DEPTH);
    localparam int P_LW     = $clog2(P_DEPTH + 1);
    localparam int A_DEPTH  = 64;
    localparam int A_AW     = $clog2(A_DEPTH);
    localparam int A_CW     = $clog2(A_DEPTH + 1);
    localparam int POS_W    = 20;
    localparam int SYM_W    = 7;
    localparam int SYM_N    = 1 << SYM_W;
    localparam int SHIFT_W  = 6;
    localparam int OP_W     = 3;
    localparam int STAT_W   = 2;
    // Remainder chain: one cell per quotient bit of the shift
    localparam int MOD_N    = SHIFT_W;
    localparam int DSH_W    = A_CW + SHIFT_W - 1;
    localparam int SETTLE_W = $clog2(MOD_N + 1);

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALPHA = 3'd0;
    localparam logic [OP_W-1:0] OP_PAT   = 3'd1;
    localparam logic [OP_W-1:0] OP_TEXT  = 3'd2;
    localparam logic [OP_W-1:0] OP_CLR   = 3'd3;
    localparam logic [OP_W-1:0] OP_RST   = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_PAT_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_ALPHA_FULL = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [SYM_W-1:0] symbol;
    } t_in_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              match_found;
        logic [POS_W-1:0]  match_start;
        logic [POS_W-1:0]  match_count;
    } t_out_req;

endpackage

`default_nettype wire

@@ hdl/rakm_ram.sv @@
// ----------------------------------------------------------------------------
// rakm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rakm_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];

    // Write, then read registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ hdl/rakm_mod_cell.sv @@
// ----------------------------------------------------------------------------
// rakm_mod_cell
// One restoring step of the shift-modulo-count remainder chain.
// ----------------------------------------------------------------------------
`default_nettype none

module rakm_mod_cell (
    input  wire logic                          i_clk,
    input  wire logic [rakm_pkg::SHIFT_W-1:0]  i_rem,
    input  wire logic [rakm_pkg::DSH_W-1:0]    i_dsh,
    output logic      [rakm_pkg::SHIFT_W-1:0]  o_rem,
    output logic      [rakm_pkg::DSH_W-1:0]    o_dsh
);
    import rakm_pkg::*;

    logic [DSH_W-1:0] rem_ext;
    logic             take;

    assign rem_ext = DSH_W'(i_rem);
    assign take    = (i_dsh != '0) && (rem_ext >= i_dsh);

    // Subtract the shifted divisor when it fits, hand down the next weight
    always_ff @(posedge i_clk) begin
        o_rem <= take ? SHIFT_W'(rem_ext - i_dsh) : i_rem;
        o_dsh <= i_dsh >> 1;
    end

endmodule

`default_nettype wire

@@ hdl/rotated_alphabet_kmp_matcher_top.sv @@
// ----------------------------------------------------------------------------
// rotated_alphabet_kmp_matcher_top
// KMP string matcher whose pattern symbols are rotated within a loaded
// alphabet before they are compared with text symbols.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready, i_in) carries one request: an
//   operation and a symbol. Every request yields exactly one result on the
//   output channel (o_out_valid/i_out_ready, o_out). The shift register is
//   written on its own channel (i_cfg_valid/o_cfg_ready, always ready).
//   One request is in work at a time. Load, clear and restart requests and
//   the first pattern symbol go straight to the result. Other pattern
//   loads compare against the new symbol and follow failure fallbacks. A
//   text symbol with a non-empty pattern compares candidates in turn,
//   falling back on each mismatch, through the shared pattern, map,
//   alphabet and failure RAM read ports in series (no alphabet read with
//   an empty alphabet).
//   After an alphabet load, a clear or a shift write, the six-cell remainder
//   chain must settle again; a text request waits for it.
//   Reset empties alphabet, map, pattern and counters, and sets shift to 0.
//   A stalled output holds its result; the next request is taken only once
//   the current one has handed its result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rotated_alphabet_kmp_matcher_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire rakm_pkg::t_in_req            i_in,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output rakm_pkg::t_out_req                o_out,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [rakm_pkg::SHIFT_W-1:0] i_cfg_shift
);
    import rakm_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DONE  = 4'd1;
    localparam logic [3:0] S_B_RD  = 4'd2;
    localparam logic [3:0] S_B_CMP = 4'd3;
    localparam logic [3:0] S_B_FL  = 4'd4;
    localparam logic [3:0] S_T_RD  = 4'd5;
    localparam logic [3:0] S_T_POS = 4'd6;
    localparam logic [3:0] S_T_ALF = 4'd7;
    localparam logic [3:0] S_T_CMP = 4'd8;
    localparam logic [3:0] S_T_FL  = 4'd9;
    localparam logic [3:0] S_T_FM  = 4'd10;

    // Control state
    logic [3:0]          r_state, n_state;
    logic [P_LW-1:0]     r_j, n_j;
    logic [A_CW-1:0]     r_acnt, n_acnt;
    logic [P_LW-1:0]     r_len, n_len;
    logic [P_LW-1:0]     r_bp, n_bp;
    logic [P_LW-1:0]     r_tp, n_tp;
    logic [POS_W-1:0]    r_tpos, n_tpos;
    logic [POS_W-1:0]    r_occ, n_occ;
    logic [SHIFT_W-1:0]  r_shift;
    logic [SYM_N-1:0]    r_valid, n_valid;
    logic [SETTLE_W-1:0] r_settle, n_settle;
    logic                r_ovalid, n_ovalid;
    // Payload
    logic [SYM_W-1:0]    r_sym, n_sym;
    logic [SYM_W-1:0]    r_p, n_p;
    t_out_req            r_res, n_res;
    t_out_req            r_out, n_out;

    // RAM ports
    logic              pat_we, fail_we, alph_we, pos_we;
    logic [P_AW-1:0]   pat_waddr, pat_raddr, fail_waddr, fail_raddr;
    logic [SYM_W-1:0]  pat_wdata, pat_rdata, alph_wdata, alph_rdata;
    logic [P_LW-1:0]   fail_wdata, fail_rdata;
    logic [A_AW-1:0]   alph_waddr, alph_raddr, pos_wdata, pos_rdata;
    logic [SYM_W-1:0]  pos_waddr;

    // Remainder chain
    logic [SHIFT_W-1:0] rem_q [MOD_N+1];
    logic [DSH_W-1:0]   dsh_q [MOD_N+1];
    logic [SHIFT_W-1:0] shift_mod;

    logic              cfg_wr, in_acc, slot_free, eq, b_eq;
    logic [P_LW-1:0]   jn;
    logic [A_AW-1:0]   pm;
    logic [A_CW-1:0]   psum, pred;
    logic [SYM_W-1:0]  rot;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign slot_free   = !r_ovalid || i_out_ready;
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    // Feed the chain with shift and count weighted by the top quotient bit
    assign rem_q[0] = r_shift;
    assign dsh_q[0] = DSH_W'(r_acnt) << (SHIFT_W - 1);
    assign shift_mod = rem_q[MOD_N];

    for (genvar g = 0; g < MOD_N; g++) begin : g_mod
        rakm_mod_cell u_cell (
            .i_clk (i_clk),
            .i_rem (rem_q[g]),
            .i_dsh (dsh_q[g]),
            .o_rem (rem_q[g+1]),
            .o_dsh (dsh_q[g+1])
        );
    end

    rakm_ram #(.W(SYM_W), .D(P_DEPTH)) u_pat (
        .i_clk(i_clk), .i_we(pat_we), .i_waddr(pat_waddr), .i_wdata(pat_wdata),
        .i_raddr(pat_raddr), .o_rdata(pat_rdata)
    );
    rakm_ram #(.W(P_LW), .D(P_DEPTH)) u_fail (
        .i_clk(i_clk), .i_we(fail_we), .i_waddr(fail_waddr), .i_wdata(fail_wdata),
        .i_raddr(fail_raddr), .o_rdata(fail_rdata)
    );
    rakm_ram #(.W(SYM_W), .D(A_DEPTH)) u_alph (
        .i_clk(i_clk), .i_we(alph_we), .i_waddr(alph_waddr), .i_wdata(alph_wdata),
        .i_raddr(alph_raddr), .o_rdata(alph_rdata)
    );
    rakm_ram #(.W(A_AW), .D(SYM_N)) u_pos (
        .i_clk(i_clk), .i_we(pos_we), .i_waddr(pos_waddr), .i_wdata(pos_wdata),
        .i_raddr(pat_rdata), .o_rdata(pos_rdata)
    );

    // Rotated symbol lookup: map position plus shift, wrapped once
    assign pm         = r_valid[r_p] ? pos_rdata : '0;
    assign psum       = A_CW'(pm) + A_CW'(shift_mod);
    assign pred       = (psum >= r_acnt) ? (psum - r_acnt) : psum;
    assign alph_raddr = pred[A_AW-1:0];
    assign rot        = (r_acnt == '0) ? r_p : alph_rdata;
    assign eq         = (r_sym == rot);
    assign b_eq       = (pat_rdata == r_sym);
    assign jn         = r_j + P_LW'(b_eq);
    assign pat_raddr  = r_j[P_AW-1:0];

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_j        = r_j;
        n_acnt     = r_acnt;
        n_len      = r_len;
        n_bp       = r_bp;
        n_tp       = r_tp;
        n_tpos     = r_tpos;
        n_occ      = r_occ;
        n_valid    = r_valid;
        n_settle   = (r_settle == SETTLE_W'(MOD_N)) ? r_settle : r_settle + 1'b1;
        n_ovalid   = r_ovalid;
        n_sym      = r_sym;
        n_p        = r_p;
        n_res      = r_res;
        n_out      = r_out;
        pat_we     = 1'b0;
        pat_waddr  = r_len[P_AW-1:0];
        pat_wdata  = i_in.symbol;
        fail_we    = 1'b0;
        fail_waddr = r_len[P_AW-1:0];
        fail_wdata = jn;
        fail_raddr = P_AW'(r_j - 1'b1);
        alph_we    = 1'b0;
        alph_waddr = r_acnt[A_AW-1:0];
        alph_wdata = i_in.symbol;
        pos_we     = 1'b0;
        pos_waddr  = i_in.symbol;
        pos_wdata  = r_acnt[A_AW-1:0];

        if (cfg_wr) begin
            n_settle = '0;
        end
        // Drop the result once taken
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res   = '0;
                    n_sym   = i_in.symbol;
                    n_state = S_DONE;
                    case (i_in.operation)
                        OP_ALPHA: begin
                            if (r_acnt < A_CW'(A_DEPTH)) begin
                                alph_we  = 1'b1;
                                pos_we   = 1'b1;
                                n_valid[i_in.symbol] = 1'b1;
                                n_acnt   = r_acnt + 1'b1;
                                n_settle = '0;
                            end else begin
                                n_res.status = ST_ALPHA_FULL;
                            end
                        end
                        OP_PAT: begin
                            if (r_len == P_LW'(P_DEPTH)) begin
                                n_res.status = ST_PAT_FULL;
                            end else begin
                                pat_we = 1'b1;
                                if (r_len == '0) begin
                                    fail_we    = 1'b1;
                                    fail_wdata = '0;
                                    n_bp       = '0;
                                    n_len      = r_len + 1'b1;
                                end else begin
                                    n_j     = r_bp;
                                    n_state = S_B_RD;
                                end
                            end
                        end
                        OP_TEXT: begin
                            if (r_len == '0) begin
                                n_tpos = r_tpos + 1'b1;
                            end else begin
                                n_j     = (r_tp >= r_len) ? '0 : r_tp;
                                n_state = S_T_RD;
                            end
                        end
                        OP_CLR: begin
                            n_acnt   = '0;
                            n_len    = '0;
                            n_bp     = '0;
                            n_tp     = '0;
                            n_valid  = '0;
                            n_settle = '0;
                        end
                        OP_RST: begin
                            n_tp   = '0;
                            n_tpos = '0;
                            n_occ  = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // Hand the result to the output register
            S_DONE: begin
                if (slot_free) begin
                    n_out             = r_res;
                    n_out.match_count = r_occ;
                    n_ovalid          = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            // Failure build: compare pattern[j] with the new symbol
            S_B_RD: begin
                n_state = S_B_CMP;
            end
            S_B_CMP: begin
                if (r_j != '0 && !b_eq) begin
                    n_state = S_B_FL;
                end else begin
                    fail_we = 1'b1;
                    n_bp    = jn;
                    n_len   = r_len + 1'b1;
                    n_state = S_DONE;
                end
            end
            S_B_FL: begin
                n_j     = fail_rdata;
                n_state = S_B_RD;
            end
            // Text: fetch pattern[j], wait for a settled shift remainder
            S_T_RD: begin
                if (r_settle == SETTLE_W'(MOD_N)) begin
                    n_state = S_T_POS;
                end
            end
            S_T_POS: begin
                n_p     = pat_rdata;
                n_state = (r_acnt == '0) ? S_T_CMP : S_T_ALF;
            end
            S_T_ALF: begin
                n_state = S_T_CMP;
            end
            S_T_CMP: begin
                if (!eq && r_j != '0) begin
                    n_state = S_T_FL;
                end else if (eq && r_j == r_len - 1'b1) begin
                    fail_raddr        = r_j[P_AW-1:0];
                    n_res.match_found = 1'b1;
                    n_res.match_start = r_tpos - POS_W'(r_j);
                    if (r_occ != '1) begin
                        n_occ = r_occ + 1'b1;
                    end
                    n_state = S_T_FM;
                end else begin
                    n_tp    = eq ? r_j + 1'b1 : '0;
                    n_tpos  = r_tpos + 1'b1;
                    n_state = S_DONE;
                end
            end
            S_T_FL: begin
                n_j     = fail_rdata;
                n_state = S_T_RD;
            end
            S_T_FM: begin
                n_tp    = fail_rdata;
                n_tpos  = r_tpos + 1'b1;
                n_state = S_DONE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_j      <= '0;
            r_acnt   <= '0;
            r_len    <= '0;
            r_bp     <= '0;
            r_tp     <= '0;
            r_tpos   <= '0;
            r_occ    <= '0;
            r_shift  <= '0;
            r_valid  <= '0;
            r_settle <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_j      <= n_j;
            r_acnt   <= n_acnt;
            r_len    <= n_len;
            r_bp     <= n_bp;
            r_tp     <= n_tp;
            r_tpos   <= n_tpos;
            r_occ    <= n_occ;
            r_valid  <= n_valid;
            r_settle <= n_settle;
            r_ovalid <= n_ovalid;
            if (cfg_wr) begin
                r_shift <= i_cfg_shift;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_sym <= n_sym;
        r_p   <= n_p;
        r_res <= n_res;
        r_out <= n_out;
    end

endmodule

`default_nettype wire
